// ----- hdl/cau_pkg.sv -----
// shared constants, types and rounding helpers for the complex arithmetic unit
`timescale 1ns / 1ps

package cau_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int THR_BITS  = WORD_BITS - 1;
    localparam int OP_BITS   = WORD_BITS + 1;
    localparam int PROD_BITS = 2 * OP_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int MAG_BITS  = 2 * WORD_BITS;
    localparam int REM_BITS  = MAG_BITS + 1;
    localparam int DIV_STEPS = WORD_BITS;
    localparam int ROOT_STEPS = WORD_BITS;

    localparam int CMUL_LAT   = 3;
    localparam int BRANCH_LAT = DIV_STEPS + 2;

    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'((2 ** FRAC_BITS) / 100);

    typedef logic [2:0] mode_t;
    localparam mode_t MODE_MUL   = 3'd0;
    localparam mode_t MODE_SQR   = 3'd1;
    localparam mode_t MODE_CUBE  = 3'd2;
    localparam mode_t MODE_RECIP = 3'd3;
    localparam mode_t MODE_MAG2  = 3'd4;
    localparam mode_t MODE_MAG   = 3'd5;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [OP_BITS-1:0]   op_t;

    typedef struct packed {
        word_t word;
        logic  sat;
    } clip_t;

    function automatic clip_t clip_word(input logic neg, input logic [SUM_BITS-1:0] mag);
        logic [SUM_BITS-1:0] lim;
        logic [SUM_BITS-1:0] m;
        clip_t r;
        lim   = (SUM_BITS'(1) << (WORD_BITS - 1)) - SUM_BITS'(!neg);
        r.sat = mag > lim;
        m     = r.sat ? lim : mag;
        r.word = neg ? -m[WORD_BITS-1:0] : m[WORD_BITS-1:0];
        return r;
    endfunction

    // truncate toward zero, then clip to the word range
    function automatic clip_t reduce_sum(input logic [SUM_BITS-1:0] x);
        logic neg;
        logic [SUM_BITS-1:0] mag;
        neg = x[SUM_BITS-1];
        mag = neg ? -x : x;
        return clip_word(neg, mag >> FRAC_BITS);
    endfunction

endpackage

// ----- hdl/cau_req_if.sv -----
// input item channel
`timescale 1ns / 1ps

interface cau_req_if;
    logic           valid;
    logic           ready;
    cau_pkg::mode_t mode;
    cau_pkg::word_t a_re;
    cau_pkg::word_t a_im;
    cau_pkg::word_t b_re;
    cau_pkg::word_t b_im;

    modport source (output valid, mode, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, mode, a_re, a_im, b_re, b_im, output ready);
endinterface

// ----- hdl/cau_rsp_if.sv -----
// result item channel
`timescale 1ns / 1ps

interface cau_rsp_if;
    logic           valid;
    logic           ready;
    cau_pkg::word_t res_re;
    cau_pkg::word_t res_im;
    logic           saturated;
    logic           near_zero;

    modport source (output valid, res_re, res_im, saturated, near_zero, input ready);
    modport sink   (input valid, res_re, res_im, saturated, near_zero, output ready);
endinterface

// ----- hdl/cau_cmul.sv -----
// three stage complex multiplier with truncation and saturation
`timescale 1ns / 1ps

module cau_cmul (
    input  logic                           clk,
    input  logic                           en,
    input  cau_pkg::op_t                   a_re,
    input  cau_pkg::op_t                   a_im,
    input  cau_pkg::op_t                   b_re,
    input  cau_pkg::op_t                   b_im,
    output cau_pkg::word_t                 res_re,
    output cau_pkg::word_t                 res_im,
    output logic                           sat,
    output logic [cau_pkg::MAG_BITS-1:0]   mag_sq
);

    logic signed [cau_pkg::PROD_BITS-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic [cau_pkg::SUM_BITS-1:0] sum_re_reg, sum_im_reg, sum_re_next, sum_im_next;
    cau_pkg::clip_t c_re_next, c_im_next;
    cau_pkg::word_t res_re_reg, res_im_reg;
    logic sat_reg;
    logic [cau_pkg::MAG_BITS-1:0] mag_sq_reg;

    always_comb
    begin
        sum_re_next = {p_rr_reg[cau_pkg::PROD_BITS-1], p_rr_reg}
                    - {p_ii_reg[cau_pkg::PROD_BITS-1], p_ii_reg};
        sum_im_next = {p_ri_reg[cau_pkg::PROD_BITS-1], p_ri_reg}
                    + {p_ir_reg[cau_pkg::PROD_BITS-1], p_ir_reg};
        c_re_next = cau_pkg::reduce_sum(sum_re_reg);
        c_im_next = cau_pkg::reduce_sum(sum_im_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_rr_reg   <= a_re * b_re;
            p_ii_reg   <= a_im * b_im;
            p_ri_reg   <= a_re * b_im;
            p_ir_reg   <= a_im * b_re;
            sum_re_reg <= sum_re_next;
            sum_im_reg <= sum_im_next;
            res_re_reg <= c_re_next.word;
            res_im_reg <= c_im_next.word;
            sat_reg    <= c_re_next.sat | c_im_next.sat;
            mag_sq_reg <= sum_re_reg[cau_pkg::MAG_BITS-1:0];
        end
    end

    assign res_re = res_re_reg;
    assign res_im = res_im_reg;
    assign sat    = sat_reg;
    assign mag_sq = mag_sq_reg;

endmodule

// ----- hdl/cau_div.sv -----
// pipelined two lane restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module cau_div (
    input  logic                           clk,
    input  logic                           en,
    input  logic [cau_pkg::WORD_BITS-1:0]  num_re,
    input  logic                           neg_re,
    input  logic [cau_pkg::WORD_BITS-1:0]  num_im,
    input  logic                           neg_im,
    input  logic [cau_pkg::MAG_BITS-1:0]   den,
    output cau_pkg::word_t                 res_re,
    output cau_pkg::word_t                 res_im,
    output logic                           sat
);

    localparam int W = cau_pkg::WORD_BITS;
    localparam int R = cau_pkg::REM_BITS;
    localparam int N = cau_pkg::DIV_STEPS;

    typedef struct packed {
        logic [R-1:0] rem;
        logic [W-1:0] quo;
        logic         ovf;
        logic         neg;
    } div_lane_t;

    div_lane_t lane_reg [0:N][0:1];
    div_lane_t lane_next [0:N][0:1];
    logic [cau_pkg::MAG_BITS-1:0] den_reg [0:N-1];
    logic [W-1:0] num [0:1];
    logic         neg [0:1];
    logic [R-1:0] shifted [1:N][0:1];
    logic         ge [1:N][0:1];
    cau_pkg::clip_t c_next [0:1];
    cau_pkg::word_t res_re_reg, res_im_reg;
    logic sat_reg;

    always_comb
    begin
        num[0] = num_re;
        num[1] = num_im;
        neg[0] = neg_re;
        neg[1] = neg_im;
        for (int l = 0; l < 2; l++)
        begin
            lane_next[0][l].rem = R'(num[l]);
            lane_next[0][l].quo = '0;
            lane_next[0][l].ovf = cau_pkg::MAG_BITS'(num[l]) >= den;
            lane_next[0][l].neg = neg[l];
            for (int k = 1; k <= N; k++)
            begin
                shifted[k][l] = {lane_reg[k-1][l].rem[R-2:0], 1'b0};
                ge[k][l] = shifted[k][l] >= {1'b0, den_reg[k-1]};
                lane_next[k][l].rem = ge[k][l] ? shifted[k][l] - {1'b0, den_reg[k-1]}
                                               : shifted[k][l];
                lane_next[k][l].quo = {lane_reg[k-1][l].quo[W-2:0], ge[k][l]};
                lane_next[k][l].ovf = lane_reg[k-1][l].ovf;
                lane_next[k][l].neg = lane_reg[k-1][l].neg;
            end
            c_next[l] = cau_pkg::clip_word(lane_reg[N][l].neg,
                lane_reg[N][l].ovf ? (cau_pkg::SUM_BITS'(1) << W)
                                   : cau_pkg::SUM_BITS'(lane_reg[N][l].quo));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= den;
            for (int k = 1; k < N; k++)
            begin
                den_reg[k] <= den_reg[k-1];
            end
            for (int k = 0; k <= N; k++)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    lane_reg[k][l] <= lane_next[k][l];
                end
            end
            res_re_reg <= c_next[0].word;
            res_im_reg <= c_next[1].word;
            sat_reg    <= c_next[0].sat | c_next[1].sat;
        end
    end

    assign res_re = res_re_reg;
    assign res_im = res_im_reg;
    assign sat    = sat_reg;

endmodule

// ----- hdl/cau_sqrt.sv -----
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps

module cau_sqrt (
    input  logic                           clk,
    input  logic                           en,
    input  logic [cau_pkg::MAG_BITS-1:0]   m,
    output cau_pkg::word_t                 root,
    output logic                           sat
);

    localparam int M = cau_pkg::MAG_BITS;
    localparam int N = cau_pkg::ROOT_STEPS;

    typedef struct packed {
        logic [M-1:0] rem;
        logic [M-1:0] res;
    } root_st_t;

    root_st_t st_reg [0:N];
    root_st_t st_next [1:N];
    logic [M-1:0] trial [1:N];
    logic [M-1:0] bitv [1:N];
    cau_pkg::clip_t c_next;
    cau_pkg::word_t root_reg;
    logic sat_reg;

    always_comb
    begin
        for (int k = 1; k <= N; k++)
        begin
            bitv[k]  = M'(1) << (M - 2 * k);
            trial[k] = st_reg[k-1].res + bitv[k];
            if (st_reg[k-1].rem >= trial[k])
            begin
                st_next[k].rem = st_reg[k-1].rem - trial[k];
                st_next[k].res = (st_reg[k-1].res >> 1) + bitv[k];
            end
            else
            begin
                st_next[k].rem = st_reg[k-1].rem;
                st_next[k].res = st_reg[k-1].res >> 1;
            end
        end
        c_next = cau_pkg::clip_word(1'b0, cau_pkg::SUM_BITS'(st_reg[N].res));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0].rem <= m;
            st_reg[0].res <= '0;
            for (int k = 1; k <= N; k++)
            begin
                st_reg[k] <= st_next[k];
            end
            root_reg <= c_next.word;
            sat_reg  <= c_next.sat;
        end
    end

    assign root = root_reg;
    assign sat  = sat_reg;

endmodule

// ----- hdl/complex_arithmetic_unit_core.sv -----
// complex arithmetic unit top level
// result valid follows item acceptance by the same pipeline depth in every mode
// throughput: one item per cycle while the output is not stalled; the divider and square root set the depth
// a stalled output freezes the whole pipeline, nothing is dropped
// reset clears all valid bits and loads the zero threshold with 655
`timescale 1ns / 1ps

module complex_arithmetic_unit_core (
    input  logic                           clk,
    input  logic                           rst_n,
    cau_req_if.sink                        req,
    cau_rsp_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [cau_pkg::THR_BITS-1:0]   cfg_wdata
);

    localparam int W         = cau_pkg::WORD_BITS;
    localparam int SIDE_LAST = cau_pkg::CMUL_LAT + cau_pkg::BRANCH_LAT;
    localparam int OUT_STAGE = SIDE_LAST + 1;
    localparam int B_FIRST   = 2 * cau_pkg::CMUL_LAT + 1;

    typedef struct packed {
        cau_pkg::mode_t mode;
        logic           nz;
        logic           sat;
        cau_pkg::word_t s_re;
        cau_pkg::word_t s_im;
    } side_t;

    typedef struct packed {
        cau_pkg::word_t re;
        cau_pkg::word_t im;
        logic           sat;
    } cube_t;

    logic [cau_pkg::THR_BITS-1:0] thr_reg;
    logic [OUT_STAGE:0] valid_reg;
    logic en;

    side_t side_reg [0:SIDE_LAST];
    side_t side_next [1:SIDE_LAST];
    cau_pkg::word_t a_re_reg [0:cau_pkg::CMUL_LAT];
    cau_pkg::word_t a_im_reg [0:cau_pkg::CMUL_LAT];
    cau_pkg::op_t b_re_reg, b_im_reg, b_re_next, b_im_next;
    cube_t cube_reg [B_FIRST:SIDE_LAST];

    cau_pkg::op_t ar_in, ai_in, thr_op;
    logic near_next;

    cau_pkg::word_t sa_re, sa_im, sb_re, sb_im, dv_re, dv_im, rt;
    logic sat_a, sat_b, sat_dv, sat_rt;
    logic [cau_pkg::MAG_BITS-1:0] mag_sq, mag_sq_unused;
    cau_pkg::word_t a3_re, a3_im;
    logic [W-1:0] num_re, num_im;

    cau_pkg::word_t res_re_reg, res_im_reg, res_re_next, res_im_next;
    logic sat_reg, nz_reg, sat_next, nz_next;
    side_t fin;

    assign en        = !valid_reg[OUT_STAGE] || rsp.ready;
    assign req.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= cau_pkg::THR_RESET;
            valid_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (en)
            begin
                valid_reg <= {valid_reg[OUT_STAGE-1:0], req.valid};
            end
        end
    end

    // operand select and zero threshold test
    always_comb
    begin
        ar_in  = {req.a_re[W-1], req.a_re};
        ai_in  = {req.a_im[W-1], req.a_im};
        thr_op = {2'b00, thr_reg};
        near_next = (ar_in > -thr_op) && (ar_in < thr_op)
                 && (ai_in > -thr_op) && (ai_in < thr_op);
        case (req.mode)
            cau_pkg::MODE_MUL:
            begin
                b_re_next = {req.b_re[W-1], req.b_re};
                b_im_next = {req.b_im[W-1], req.b_im};
            end
            cau_pkg::MODE_SQR, cau_pkg::MODE_CUBE:
            begin
                b_re_next = ar_in;
                b_im_next = ai_in;
            end
            default:
            begin
                b_re_next = ar_in;
                b_im_next = -ai_in;
            end
        endcase
    end

    cau_cmul u_cmul_a (
        .clk    (clk),
        .en     (en),
        .a_re   ({a_re_reg[0][W-1], a_re_reg[0]}),
        .a_im   ({a_im_reg[0][W-1], a_im_reg[0]}),
        .b_re   (b_re_reg),
        .b_im   (b_im_reg),
        .res_re (sa_re),
        .res_im (sa_im),
        .sat    (sat_a),
        .mag_sq (mag_sq)
    );

    assign a3_re  = a_re_reg[cau_pkg::CMUL_LAT];
    assign a3_im  = a_im_reg[cau_pkg::CMUL_LAT];
    assign num_re = a3_re[W-1] ? -a3_re : a3_re;
    assign num_im = a3_im[W-1] ? -a3_im : a3_im;

    cau_cmul u_cmul_b (
        .clk    (clk),
        .en     (en),
        .a_re   ({a3_re[W-1], a3_re}),
        .a_im   ({a3_im[W-1], a3_im}),
        .b_re   ({sa_re[W-1], sa_re}),
        .b_im   ({sa_im[W-1], sa_im}),
        .res_re (sb_re),
        .res_im (sb_im),
        .sat    (sat_b),
        .mag_sq (mag_sq_unused)
    );

    cau_div u_div (
        .clk    (clk),
        .en     (en),
        .num_re (num_re),
        .neg_re (a3_re[W-1]),
        .num_im (num_im),
        .neg_im (!a3_im[W-1] && (a3_im != '0)),
        .den    (mag_sq),
        .res_re (dv_re),
        .res_im (dv_im),
        .sat    (sat_dv)
    );

    cau_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .m    (mag_sq),
        .root (rt),
        .sat  (sat_rt)
    );

    always_comb
    begin
        for (int k = 1; k <= SIDE_LAST; k++)
        begin
            side_next[k] = side_reg[k-1];
        end
        side_next[cau_pkg::CMUL_LAT+1].nz   = side_reg[cau_pkg::CMUL_LAT].nz || (mag_sq == '0);
        side_next[cau_pkg::CMUL_LAT+1].sat  = sat_a;
        side_next[cau_pkg::CMUL_LAT+1].s_re = sa_re;
        side_next[cau_pkg::CMUL_LAT+1].s_im = sa_im;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].mode <= req.mode;
            side_reg[0].nz   <= near_next;
            side_reg[0].sat  <= 1'b0;
            side_reg[0].s_re <= '0;
            side_reg[0].s_im <= '0;
            a_re_reg[0]      <= req.a_re;
            a_im_reg[0]      <= req.a_im;
            b_re_reg         <= b_re_next;
            b_im_reg         <= b_im_next;
            for (int k = 1; k <= SIDE_LAST; k++)
            begin
                side_reg[k] <= side_next[k];
            end
            for (int k = 1; k <= cau_pkg::CMUL_LAT; k++)
            begin
                a_re_reg[k] <= a_re_reg[k-1];
                a_im_reg[k] <= a_im_reg[k-1];
            end
            cube_reg[B_FIRST] <= '{re: sb_re, im: sb_im, sat: sat_b};
            for (int k = B_FIRST + 1; k <= SIDE_LAST; k++)
            begin
                cube_reg[k] <= cube_reg[k-1];
            end
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            sat_reg    <= sat_next;
            nz_reg     <= nz_next;
        end
    end

    // result select per mode
    always_comb
    begin
        fin         = side_reg[SIDE_LAST];
        res_re_next = '0;
        res_im_next = '0;
        sat_next    = 1'b0;
        nz_next     = 1'b0;
        case (fin.mode)
            cau_pkg::MODE_MUL, cau_pkg::MODE_SQR:
            begin
                res_re_next = fin.s_re;
                res_im_next = fin.s_im;
                sat_next    = fin.sat;
            end
            cau_pkg::MODE_CUBE:
            begin
                res_re_next = cube_reg[SIDE_LAST].re;
                res_im_next = cube_reg[SIDE_LAST].im;
                sat_next    = fin.sat | cube_reg[SIDE_LAST].sat;
            end
            cau_pkg::MODE_RECIP:
            begin
                nz_next = fin.nz;
                if (!fin.nz)
                begin
                    res_re_next = dv_re;
                    res_im_next = dv_im;
                    sat_next    = sat_dv;
                end
            end
            cau_pkg::MODE_MAG2:
            begin
                res_re_next = fin.s_re;
                sat_next    = fin.sat;
            end
            cau_pkg::MODE_MAG:
            begin
                res_re_next = rt;
                sat_next    = sat_rt;
            end
            default:
            begin
                res_re_next = '0;
            end
        endcase
    end

    assign rsp.valid     = valid_reg[OUT_STAGE];
    assign rsp.res_re    = res_re_reg;
    assign rsp.res_im    = res_im_reg;
    assign rsp.saturated = sat_reg;
    assign rsp.near_zero = nz_reg;

endmodule

// ----- tb/tb_complex_arithmetic_unit_core.sv -----
// self-checking testbench for the complex arithmetic unit core
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit_core;

    localparam int LATENCY = 39;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        sat;
        logic        nz;
    } cresult_t;

    typedef struct {
        cau_pkg::mode_t mode;
        logic [31:0]    ar;
        logic [31:0]    ai;
        logic [31:0]    br;
        logic [31:0]    bi;
        logic           typed;
        cresult_t       res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [cau_pkg::THR_BITS-1:0] cfg_wdata = '0;

    cau_req_if req ();
    cau_rsp_if rsp ();

    complex_arithmetic_unit_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    cresult_t    expected_q[$];
    logic [30:0] threshold = 31'd655;
    int          mismatches = 0;
    int          errors = 0;
    int          idle_cycles = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          mode_count[8];
    bit          timed_out = 1'b0;

    function automatic logic [127:0] absval(input logic signed [127:0] x);
        return x < 0 ? -x : x;
    endfunction

    // truncate toward zero and clip to the word range
    function automatic logic [31:0] shrink(input logic signed [127:0] x, input int shift,
                                           inout logic sat);
        logic [127:0] m;
        logic [127:0] lim;
        logic         neg;
        neg = x < 0;
        m = absval(x) >> shift;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (m > lim)
        begin
            m = lim;
            sat = 1'b1;
        end
        return neg ? -m[31:0] : m[31:0];
    endfunction

    function automatic void cmul_q(input logic signed [31:0] ar, ai, br, bi,
                                   output logic [31:0] rr, ri, inout logic sat);
        logic signed [127:0] re;
        logic signed [127:0] im;
        re = 128'(ar) * 128'(br) - 128'(ai) * 128'(bi);
        im = 128'(ar) * 128'(bi) + 128'(ai) * 128'(br);
        rr = shrink(re, cau_pkg::FRAC_BITS, sat);
        ri = shrink(im, cau_pkg::FRAC_BITS, sat);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] m);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > m)
            b = b >> 2;
        while (b != 0)
        begin
            if (m >= r + b)
            begin
                m = m - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic cresult_t complex_result(input stim_row_t s, input logic [30:0] thr);
        cresult_t            o;
        logic signed [31:0]  ar;
        logic signed [31:0]  ai;
        logic signed [127:0] t;
        logic signed [127:0] m2;
        logic [31:0]         sr;
        logic [31:0]         si;
        logic [63:0]         rt;
        ar = s.ar;
        ai = s.ai;
        t = 128'(thr);
        o = '{re: 0, im: 0, sat: 0, nz: 0};
        m2 = 128'(ar) * 128'(ar) + 128'(ai) * 128'(ai);
        case (s.mode)
            cau_pkg::MODE_MUL: cmul_q(ar, ai, s.br, s.bi, o.re, o.im, o.sat);
            cau_pkg::MODE_SQR: cmul_q(ar, ai, ar, ai, o.re, o.im, o.sat);
            cau_pkg::MODE_CUBE:
            begin
                cmul_q(ar, ai, ar, ai, sr, si, o.sat);
                cmul_q(ar, ai, sr, si, o.re, o.im, o.sat);
            end
            cau_pkg::MODE_RECIP:
            begin
                if ((128'(ar) > -t && 128'(ar) < t && 128'(ai) > -t && 128'(ai) < t) || m2 == 0)
                    o.nz = 1'b1;
                else
                begin
                    o.re = shrink((128'(ar) <<< 32) / m2, 0, o.sat);
                    o.im = shrink(-(128'(ai) <<< 32) / m2, 0, o.sat);
                end
            end
            cau_pkg::MODE_MAG2: o.re = shrink(m2, cau_pkg::FRAC_BITS, o.sat);
            cau_pkg::MODE_MAG:
            begin
                rt = root64(m2[63:0]);
                o.re = shrink(128'(rt), 0, o.sat);
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic send_item(input stim_row_t s);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.mode  <= s.mode;
        req.a_re  <= s.ar;
        req.a_im  <= s.ai;
        req.b_re  <= s.br;
        req.b_im  <= s.bi;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        expected_q.push_back(s.typed ? s.res : complex_result(s, threshold));
        mode_count[s.mode]++;
        items_sent++;
    endtask

    task automatic drain_then_write(input logic [30:0] v);
        req.valid <= 1'b0;
        while (expected_q.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        threshold = v;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(65535) - 32768;
            3: return ($urandom_range(1023) << 16) - 32'd33554432 + $urandom_range(65535);
            default: return $urandom;
        endcase
    endfunction

    function automatic stim_row_t rand_row();
        stim_row_t s;
        s.mode  = $urandom_range(99) < 3 ? cau_pkg::mode_t'($urandom_range(7, 6))
                                         : cau_pkg::mode_t'($urandom_range(5));
        s.ar    = rand_word();
        s.ai    = rand_word();
        s.br    = rand_word();
        s.bi    = rand_word();
        s.typed = 1'b0;
        s.res   = '{re: 0, im: 0, sat: 0, nz: 0};
        return s;
    endfunction

    stim_row_t directed[] = '{
        '{cau_pkg::MODE_RECIP, 32'd0, 32'd0, 0, 0, 1, '{0, 0, 0, 1}},
        '{cau_pkg::MODE_RECIP, 32'd654, -32'sd654, 0, 0, 1, '{0, 0, 0, 1}},
        '{cau_pkg::MODE_RECIP, 32'd655, 32'd0, 0, 0, 0, '{0, 0, 0, 0}},
        '{cau_pkg::MODE_RECIP, 32'h0001_0000, 32'd0, 0, 0, 1, '{32'h0001_0000, 0, 0, 0}},
        '{cau_pkg::MODE_MUL, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1,
          '{0, 32'h0002_0000, 0, 0}},
        '{cau_pkg::MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
          '{0, 32'h7fff_ffff, 1, 0}},
        '{cau_pkg::MODE_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0,
          '{0, 0, 0, 0}},
        '{cau_pkg::MODE_SQR, 32'h8000_0000, 32'h0, 0, 0, 1, '{32'h7fff_ffff, 0, 1, 0}},
        '{cau_pkg::MODE_SQR, 32'hffff_ffff, 32'h0001_0000, 0, 0, 0, '{0, 0, 0, 0}},
        '{cau_pkg::MODE_CUBE, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, '{0, 0, 0, 0}},
        '{cau_pkg::MODE_CUBE, 32'h0100_0000, 32'h0, 0, 0, 1, '{32'h7fff_ffff, 0, 1, 0}},
        '{cau_pkg::MODE_RECIP, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, '{0, 0, 0, 0}},
        '{cau_pkg::MODE_RECIP, 32'h0000_0400, 32'h0, 0, 0, 1, '{32'h0040_0000, 0, 0, 0}},
        '{cau_pkg::MODE_RECIP, 32'hffff_fc00, 32'h0, 0, 0, 1, '{32'hffc0_0000, 0, 0, 0}},
        '{cau_pkg::MODE_MAG2, 32'h8000_0000, 32'h8000_0000, 0, 0, 1, '{32'h7fff_ffff, 0, 1, 0}},
        '{cau_pkg::MODE_MAG2, 32'h0002_0000, 32'h0, 0, 0, 1, '{32'h0004_0000, 0, 0, 0}},
        '{cau_pkg::MODE_MAG, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, '{0, 0, 0, 0}},
        '{cau_pkg::MODE_MAG, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, '{0, 0, 0, 0}},
        '{cau_pkg::MODE_MAG, 32'd3, 32'd4, 0, 0, 1, '{32'd5, 0, 0, 0}},
        '{cau_pkg::mode_t'(3'd6), 32'h1234_5678, 32'h8765_4321, 32'hffff_ffff, 1, 1,
          '{0, 0, 0, 0}},
        '{cau_pkg::mode_t'(3'd7), 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1,
          '{0, 0, 0, 0}}
    };

    always @(posedge clk)
    begin
        rsp.ready <= !(snk_stall_pct > 0 && $urandom_range(99) < snk_stall_pct);
    end

    always @(posedge clk)
    begin
        cresult_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result re=%h im=%h", rsp.res_re, rsp.res_im);
            end
            else
            begin
                e = expected_q.pop_front();
                if (rsp.res_re !== e.re || rsp.res_im !== e.im ||
                    rsp.saturated !== e.sat || rsp.near_zero !== e.nz)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch exp re=%h im=%h sat=%b nz=%b got re=%h im=%h sat=%b nz=%b",
                                 e.re, e.im, e.sat, e.nz, rsp.res_re, rsp.res_im,
                                 rsp.saturated, rsp.near_zero);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int n;
        req.valid = 1'b0;
        req.mode  = cau_pkg::MODE_MUL;
        req.a_re  = '0;
        req.a_im  = '0;
        req.b_re  = '0;
        req.b_im  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_item(directed[i]);
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 70; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 70; end
                default: begin src_idle_pct = 7; snk_stall_pct = 7; end
            endcase
            case (ph)
                1: drain_then_write(31'd0);
                3: drain_then_write(31'h7fff_ffff);
                5: drain_then_write(31'($urandom_range(32'h0004_0000)));
                7: drain_then_write(31'd655);
                default: ;
            endcase
            n = 0;
            while (n < 116)
            begin
                send_item(rand_row());
                n++;
            end
        end
        req.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("sent %0d items over four threshold settings, %0d results checked", items_sent,
                 results_seen);
        $display("modes mul %0d sqr %0d cube %0d recip %0d mag2 %0d mag %0d unused %0d",
                 mode_count[0], mode_count[1], mode_count[2], mode_count[3], mode_count[4],
                 mode_count[5], mode_count[6] + mode_count[7]);
        if (errors == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
